@@ sv/tmai_pkg.sv @@
// shared types, constants and the microcode table of the mlp inference block
package tmai_pkg;

  // default network shape
  localparam int NUM_INPUTS_DEF  = 8;
  localparam int HIDDEN_ONE_DEF  = 3;
  localparam int HIDDEN_TWO_DEF  = 2;
  localparam int NUM_OUTPUTS_DEF = 9;
  localparam int WEIGHT_BITS_DEF = 16;

  // fixed formats
  localparam int FRAC_BITS   = 12;
  localparam int LIVE_INPUTS = 3;
  localparam int ACT_BITS    = 32;
  localparam int ACC_BITS    = 64;
  localparam int ACTION_BITS = 4;
  localparam int WIDX_BITS   = 6;
  localparam int WVAL_BITS   = 16;
  localparam int POS_BITS    = 10;
  localparam int PREV_BITS   = 4;

  localparam int STEP_BITS = 3;

  typedef logic [STEP_BITS-1:0] step_t;

  // program addresses
  localparam step_t STEP_IDLE    = 3'd0;
  localparam step_t STEP_NEURON  = 3'd1;
  localparam step_t STEP_MAC     = 3'd2;
  localparam step_t STEP_DRAIN_A = 3'd3;
  localparam step_t STEP_DRAIN_B = 3'd4;
  localparam step_t STEP_FINISH  = 3'd5;
  localparam step_t STEP_NEXT    = 3'd6;
  localparam step_t STEP_EMIT    = 3'd7;

  typedef enum logic [1:0] {
    LAYER_ONE,
    LAYER_TWO,
    LAYER_THREE
  } layer_e;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_CLEAR,
    OP_ISSUE,
    OP_FINISH,
    OP_NEXT,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    JMP_NEVER,
    JMP_IDLE,
    JMP_K_MORE,
    JMP_J_MORE,
    JMP_L_MORE,
    JMP_ALWAYS
  } jump_e;

  typedef struct packed {
    op_e   op;
    jump_e jump;
    step_t target;
  } uword_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic go;
    logic k_more;
    logic j_more;
    logic l_more;
  } flags_t;

  // sequencer commands to the datapath
  typedef struct packed {
    op_e  op;
    logic busy;
  } ctrl_t;

  function automatic uword_t ucode_rom(step_t s);
    uword_t w;
    unique case (s)
      STEP_IDLE:    w = '{op: OP_NOP,    jump: JMP_IDLE,   target: STEP_IDLE};
      STEP_NEURON:  w = '{op: OP_CLEAR,  jump: JMP_NEVER,  target: STEP_IDLE};
      STEP_MAC:     w = '{op: OP_ISSUE,  jump: JMP_K_MORE, target: STEP_MAC};
      STEP_DRAIN_A: w = '{op: OP_NOP,    jump: JMP_NEVER,  target: STEP_IDLE};
      STEP_DRAIN_B: w = '{op: OP_NOP,    jump: JMP_NEVER,  target: STEP_IDLE};
      STEP_FINISH:  w = '{op: OP_FINISH, jump: JMP_J_MORE, target: STEP_NEURON};
      STEP_NEXT:    w = '{op: OP_NEXT,   jump: JMP_L_MORE, target: STEP_NEURON};
      STEP_EMIT:    w = '{op: OP_EMIT,   jump: JMP_ALWAYS, target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

@@ sv/tiny_mlp_argmax_inference.sv @@
// top level: weight store, multiply-accumulate datapath and argmax of the mlp
// a load transfer writes one weight and leaves busy_o low
// an infer transfer raises busy_o; per neuron the sequencer clears, issues one product
// per input (layer one runs over its three live inputs), drains and finishes; after
// the last layer done_o strobes for one cycle
// the single multiplier and one weight-store read port serve every layer; done_o cannot stall
// reset clears the sequencer and counters only; weights stay undefined until loaded
module tiny_mlp_argmax_inference #(
  parameter int NUM_INPUTS  = tmai_pkg::NUM_INPUTS_DEF,
  parameter int HIDDEN_ONE  = tmai_pkg::HIDDEN_ONE_DEF,
  parameter int HIDDEN_TWO  = tmai_pkg::HIDDEN_TWO_DEF,
  parameter int NUM_OUTPUTS = tmai_pkg::NUM_OUTPUTS_DEF,
  parameter int WEIGHT_BITS = tmai_pkg::WEIGHT_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  logic                                  func_i,
  input  logic [tmai_pkg::WIDX_BITS-1:0]        weight_index_i,
  input  logic signed [tmai_pkg::WVAL_BITS-1:0] weight_value_i,
  input  logic [tmai_pkg::POS_BITS-1:0]         pos_x_i,
  input  logic [tmai_pkg::POS_BITS-1:0]         pos_y_i,
  input  logic [tmai_pkg::PREV_BITS-1:0]        prev_action_i,
  output logic                                  done_o,
  output logic [tmai_pkg::ACTION_BITS-1:0]      action_o,
  output logic [tmai_pkg::ACT_BITS-1:0]         best_score_o
);

  // weight layout: layer one, then two, then three, each [input][neuron]
  localparam int BASE_TWO   = NUM_INPUTS * HIDDEN_ONE;
  localparam int BASE_THREE = BASE_TWO + HIDDEN_ONE * HIDDEN_TWO;
  localparam int TOTAL      = BASE_THREE + HIDDEN_TWO * NUM_OUTPUTS;
  localparam int ADDR_BITS  = $clog2(TOTAL);
  localparam int IDX_BITS   = (ADDR_BITS > tmai_pkg::WIDX_BITS) ? ADDR_BITS
                                                                : tmai_pkg::WIDX_BITS;

  // activation files hold at most this many values
  localparam int MAX_MID = (HIDDEN_ONE > HIDDEN_TWO) ? HIDDEN_ONE : HIDDEN_TWO;
  localparam int MAX_IN  = (MAX_MID > tmai_pkg::LIVE_INPUTS) ? MAX_MID
                                                             : tmai_pkg::LIVE_INPUTS;
  localparam int MAX_OUT = (MAX_MID > NUM_OUTPUTS) ? MAX_MID : NUM_OUTPUTS;
  localparam int K_BITS  = $clog2(MAX_IN);
  localparam int J_BITS  = $clog2(MAX_OUT);

  localparam int ACT_BITS  = tmai_pkg::ACT_BITS;
  localparam int ACC_BITS  = tmai_pkg::ACC_BITS;
  localparam int PROD_BITS = ACT_BITS + 1 + WEIGHT_BITS;
  localparam int SUM_BITS  = ((PROD_BITS > ACC_BITS) ? PROD_BITS : ACC_BITS) + 1;

  // accumulator clamps at +/- 2^62
  localparam logic signed [ACC_BITS-1:0] ACC_MAX = 64'sh4000_0000_0000_0000;
  localparam logic signed [ACC_BITS-1:0] ACC_MIN = -ACC_MAX;

  // stored weight range
  localparam longint WMAX_L = (64'sd1 <<< (WEIGHT_BITS - 1)) - 64'sd1;
  localparam logic signed [33:0] W_HI = 34'(WMAX_L);
  localparam logic signed [33:0] W_LO = 34'(-WMAX_L - 64'sd1);

  tmai_pkg::flags_t flags;
  tmai_pkg::ctrl_t  ctrl;

  logic load_go, infer_go;
  logic idx_ok;
  logic [IDX_BITS-1:0]       widx_ext;
  logic signed [33:0]        wv_ext, wv_sat;

  // weight store
  logic signed [WEIGHT_BITS-1:0] mem_q [TOTAL];
  logic signed [WEIGHT_BITS-1:0] rdata_q;

  // sequencing state
  tmai_pkg::layer_e    layer_q, layer_next;
  logic [J_BITS-1:0]   j_q;
  logic [K_BITS-1:0]   k_q;
  logic [ADDR_BITS-1:0] addr_q;

  // per-layer shape
  logic [K_BITS-1:0]    k_last;
  logic [J_BITS-1:0]    j_last;
  logic [ADDR_BITS-1:0] stride, base;

  // activations and pipeline
  logic [ACT_BITS-1:0]        in_act_q  [MAX_IN];
  logic [ACT_BITS-1:0]        out_act_q [MAX_IN];
  logic [ACT_BITS-1:0]        act_sel_q;
  logic signed [PROD_BITS-1:0] prod_q;
  logic signed [ACC_BITS-1:0]  acc_q;
  logic signed [SUM_BITS-1:0]  sum;
  logic signed [ACC_BITS-1:0]  acc_sat;
  logic                        v1_q, v2_q;

  // neuron output after relu
  logic [ACC_BITS-1:0] acc_shr;
  logic [ACT_BITS-1:0] score;

  // argmax
  logic [J_BITS-1:0]   action_q;
  logic [ACT_BITS-1:0] best_q;

  tmai_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  assign busy_o   = ctrl.busy;
  assign done_o   = (ctrl.op == tmai_pkg::OP_EMIT);
  assign action_o = tmai_pkg::ACTION_BITS'(action_q);
  assign best_score_o = best_q;

  // a transfer either loads a weight or starts an inference
  assign load_go  = start_i & ~busy_o & ~func_i;
  assign infer_go = start_i & ~busy_o & func_i;

  // loads past the end of the store are dropped
  assign widx_ext = IDX_BITS'(weight_index_i);
  assign idx_ok   = (widx_ext < IDX_BITS'(TOTAL));

  // clamp the incoming weight to the stored width
  always_comb begin
    wv_ext = 34'(weight_value_i);
    if (wv_ext > W_HI) begin
      wv_sat = W_HI;
    end else if (wv_ext < W_LO) begin
      wv_sat = W_LO;
    end else begin
      wv_sat = wv_ext;
    end
  end

  // shape of the layer in progress
  always_comb begin
    unique case (layer_q)
      tmai_pkg::LAYER_ONE: begin
        k_last     = K_BITS'(tmai_pkg::LIVE_INPUTS - 1);
        j_last     = J_BITS'(HIDDEN_ONE - 1);
        stride     = ADDR_BITS'(HIDDEN_ONE);
        base       = '0;
        layer_next = tmai_pkg::LAYER_TWO;
      end
      tmai_pkg::LAYER_TWO: begin
        k_last     = K_BITS'(HIDDEN_ONE - 1);
        j_last     = J_BITS'(HIDDEN_TWO - 1);
        stride     = ADDR_BITS'(HIDDEN_TWO);
        base       = ADDR_BITS'(BASE_TWO);
        layer_next = tmai_pkg::LAYER_THREE;
      end
      tmai_pkg::LAYER_THREE: begin
        k_last     = K_BITS'(HIDDEN_TWO - 1);
        j_last     = J_BITS'(NUM_OUTPUTS - 1);
        stride     = ADDR_BITS'(NUM_OUTPUTS);
        base       = ADDR_BITS'(BASE_THREE);
        layer_next = tmai_pkg::LAYER_THREE;
      end
      default: begin
        k_last     = '0;
        j_last     = '0;
        stride     = '0;
        base       = '0;
        layer_next = tmai_pkg::LAYER_ONE;
      end
    endcase
  end

  always_comb begin
    flags.go     = infer_go;
    flags.k_more = (k_q != k_last);
    flags.j_more = (j_q != j_last);
    flags.l_more = (layer_q != tmai_pkg::LAYER_THREE);
  end

  // saturating accumulate, exact sum then clamp
  always_comb begin
    sum = SUM_BITS'(acc_q) + SUM_BITS'(prod_q);
    if (sum > SUM_BITS'(ACC_MAX)) begin
      acc_sat = ACC_MAX;
    end else if (sum < SUM_BITS'(ACC_MIN)) begin
      acc_sat = ACC_MIN;
    end else begin
      acc_sat = sum[ACC_BITS-1:0];
    end
  end

  // relu, drop the fraction, clamp at the top of the activation range
  always_comb begin
    acc_shr = ACC_BITS'(acc_q >>> tmai_pkg::FRAC_BITS);
    if (acc_q[ACC_BITS-1] || acc_q == '0) begin
      score = '0;
    end else if (|acc_shr[ACC_BITS-1:ACT_BITS]) begin
      score = '1;
    end else begin
      score = acc_shr[ACT_BITS-1:0];
    end
  end

  // weight store write and registered read
  always_ff @(posedge clk_i) begin
    if (load_go && idx_ok) begin
      mem_q[widx_ext[ADDR_BITS-1:0]] <= wv_sat[WEIGHT_BITS-1:0];
    end
    if (ctrl.op == tmai_pkg::OP_ISSUE) begin
      rdata_q   <= mem_q[addr_q];
      act_sel_q <= in_act_q[k_q];
    end
  end

  // counters and address walk
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer_q <= tmai_pkg::LAYER_ONE;
      j_q     <= '0;
      k_q     <= '0;
      addr_q  <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
    end else begin
      v1_q <= (ctrl.op == tmai_pkg::OP_ISSUE);
      v2_q <= v1_q;
      if (infer_go) begin
        layer_q <= tmai_pkg::LAYER_ONE;
        j_q     <= '0;
      end
      unique case (ctrl.op)
        tmai_pkg::OP_CLEAR: begin
          k_q    <= '0;
          addr_q <= base + ADDR_BITS'(j_q);
        end
        tmai_pkg::OP_ISSUE: begin
          k_q    <= k_q + K_BITS'(1);
          addr_q <= addr_q + stride;
        end
        tmai_pkg::OP_FINISH: begin
          if (flags.j_more) begin
            j_q <= j_q + J_BITS'(1);
          end
        end
        tmai_pkg::OP_NEXT: begin
          layer_q <= layer_next;
          j_q     <= '0;
        end
        default: ;
      endcase
    end
  end

  // multiply, accumulate, activations and argmax
  always_ff @(posedge clk_i) begin
    prod_q <= PROD_BITS'($signed({1'b0, act_sel_q})) * PROD_BITS'(rdata_q);

    if (ctrl.op == tmai_pkg::OP_CLEAR) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_sat;
    end

    // the network inputs beyond the first three are zero
    if (infer_go) begin
      for (int i = tmai_pkg::LIVE_INPUTS; i < MAX_IN; i++) begin
        in_act_q[i] <= '0;
      end
      in_act_q[0] <= ACT_BITS'(pos_x_i) << tmai_pkg::FRAC_BITS;
      in_act_q[1] <= ACT_BITS'(pos_y_i) << tmai_pkg::FRAC_BITS;
      in_act_q[2] <= ACT_BITS'(prev_action_i) << tmai_pkg::FRAC_BITS;
    end else if (ctrl.op == tmai_pkg::OP_NEXT) begin
      in_act_q <= out_act_q;
    end

    if (ctrl.op == tmai_pkg::OP_FINISH) begin
      if (layer_q == tmai_pkg::LAYER_THREE) begin
        // later index wins a tie
        if (j_q == '0 || score >= best_q) begin
          best_q   <= score;
          action_q <= j_q;
        end
      end else begin
        for (int i = 0; i < MAX_IN; i++) begin
          if (j_q == J_BITS'(i)) begin
            out_act_q[i] <= score;
          end
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  // an infer transfer makes the block busy in the next cycle
  a_infer_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && func_i |=> busy_o)
    else $error("infer transfer did not start the sequencer");

  // a load transfer never starts the sequencer
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && !func_i |=> !busy_o)
    else $error("load transfer started the sequencer");

  // the result strobe lasts one cycle and ends the busy period
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy_o)
    else $error("result strobe held or block still busy");

  // no result while the accumulator pipeline still carries products
  a_done_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !v1_q && !v2_q)
    else $error("result strobe with products in flight");
`endif

endmodule

@@ sv/tmai_seq.sv @@
// microcode sequencer: step counter, control table and conditional jumps
module tmai_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tmai_pkg::flags_t flags_i,
  output tmai_pkg::ctrl_t  ctrl_o
);

  tmai_pkg::step_t  step_q, step_d;
  tmai_pkg::uword_t uw;
  logic             taken;

  assign uw = tmai_pkg::ucode_rom(step_q);

  // next step
  always_comb begin
    unique case (uw.jump)
      tmai_pkg::JMP_NEVER:  taken = 1'b0;
      tmai_pkg::JMP_IDLE:   taken = ~flags_i.go;
      tmai_pkg::JMP_K_MORE: taken = flags_i.k_more;
      tmai_pkg::JMP_J_MORE: taken = flags_i.j_more;
      tmai_pkg::JMP_L_MORE: taken = flags_i.l_more;
      tmai_pkg::JMP_ALWAYS: taken = 1'b1;
      default:              taken = 1'b0;
    endcase
    step_d = taken ? uw.target : step_q + tmai_pkg::step_t'(1);
  end

  // outputs
  always_comb begin
    ctrl_o.op   = uw.op;
    ctrl_o.busy = (step_q != tmai_pkg::STEP_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= tmai_pkg::STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

@@ tb/tiny_mlp_argmax_inference_test.sv @@
// testbench of the mlp inference block: predicted argmax decisions checked at each done strobe
module tiny_mlp_argmax_inference_test;

  // network shape and derived weight layout
  localparam int N_IN        = tmai_pkg::NUM_INPUTS_DEF;
  localparam int N_H1        = tmai_pkg::HIDDEN_ONE_DEF;
  localparam int N_H2        = tmai_pkg::HIDDEN_TWO_DEF;
  localparam int N_OUT       = tmai_pkg::NUM_OUTPUTS_DEF;
  localparam int FRAC        = tmai_pkg::FRAC_BITS;
  localparam int BASE_TWO    = N_IN * N_H1;
  localparam int BASE_THREE  = BASE_TWO + N_H1 * N_H2;
  localparam int TOTAL_WTS   = BASE_THREE + N_H2 * N_OUT;
  localparam int W_MAX       = (1 << (tmai_pkg::WEIGHT_BITS_DEF - 1)) - 1;
  localparam longint ACC_LIMIT = longint'(1) << 62;

  // idle margin after the last result, before the summary is printed
  localparam int SETTLE_CYCLES = 100;
  localparam int RANDOM_ITEMS  = 690;

  // function codes of an input transfer
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_INFER = 1'b1;

  // fixed-point landmarks used by the directed tests
  localparam logic [15:0] W_ONE     = 16'h1000;
  localparam logic [15:0] W_MINUS   = 16'hF000;
  localparam logic [15:0] W_TOP     = 16'h7FFF;
  localparam logic [15:0] W_BOTTOM  = 16'h8000;
  localparam logic [9:0]  POS_TOP   = 10'h3FF;
  localparam logic [3:0]  PREV_TOP  = 4'hF;

  typedef struct packed {
    logic [tmai_pkg::ACTION_BITS-1:0] action;
    logic [tmai_pkg::ACT_BITS-1:0]    score;
  } decision_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // command side, all driven to known values from time zero
  logic                                  start_i        = 1'b0;
  logic                                  func_i         = FUNC_LOAD;
  logic [tmai_pkg::WIDX_BITS-1:0]        weight_index_i = '0;
  logic signed [tmai_pkg::WVAL_BITS-1:0] weight_value_i = '0;
  logic [tmai_pkg::POS_BITS-1:0]         pos_x_i        = '0;
  logic [tmai_pkg::POS_BITS-1:0]         pos_y_i        = '0;
  logic [tmai_pkg::PREV_BITS-1:0]        prev_action_i  = '0;

  // result side
  logic                             busy_o;
  logic                             done_o;
  logic [tmai_pkg::ACTION_BITS-1:0] action_o;
  logic [tmai_pkg::ACT_BITS-1:0]    best_score_o;

  // predictor state: our own copy of the weight store
  int        weight_copy [TOTAL_WTS];
  decision_t pending_decisions [$];

  // bookkeeping
  int n_mismatches   = 0;
  int n_accepted     = 0;
  int n_loads        = 0;
  int n_ignored      = 0;
  int n_infers       = 0;
  int n_checked      = 0;
  int n_saturated    = 0;
  int n_zero_scores  = 0;
  int n_epochs       = 0;
  int burst_left     = 0;

  always #4 clk_i = ~clk_i;

  tiny_mlp_argmax_inference i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .func_i         (func_i),
    .weight_index_i (weight_index_i),
    .weight_value_i (weight_value_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .prev_action_i  (prev_action_i),
    .done_o         (done_o),
    .action_o       (action_o),
    .best_score_o   (best_score_o)
  );

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // one neuron: saturating sum of exact q.24 products, relu, back to q20.12
  function automatic logic [31:0] fire_neuron(input logic [15:0][31:0] act_in, input int n_in,
                                              input int n_out, input int base, input int j);
    longint acc;
    longint prod;
    longint shifted;
    acc = 0;
    for (int k = 0; k < n_in; k++) begin
      prod = longint'({32'd0, act_in[k]}) * longint'(weight_copy[base + k * n_out + j]);
      if (prod > 0 && acc > ACC_LIMIT - prod) acc = ACC_LIMIT;
      else if (prod < 0 && acc < -ACC_LIMIT - prod) acc = -ACC_LIMIT;
      else acc = acc + prod;
    end
    // relu acts on the whole sum, never on partial sums
    if (acc <= 0) return '0;
    shifted = acc >>> FRAC;
    if (shifted > longint'(32'hFFFF_FFFF)) return '1;
    return shifted[31:0];
  endfunction

  // full forward pass and argmax, later ties winning
  function automatic decision_t infer_decision(input logic [9:0] x, input logic [9:0] y,
                                               input logic [3:0] p);
    logic [15:0][31:0] a0;
    logic [15:0][31:0] a1;
    logic [15:0][31:0] a2;
    logic [15:0][31:0] a3;
    decision_t d;
    a0 = '0;
    a1 = '0;
    a2 = '0;
    a3 = '0;
    // only the first three inputs are live, the rest stay zero
    a0[0] = 32'(x) << FRAC;
    a0[1] = 32'(y) << FRAC;
    a0[2] = 32'(p) << FRAC;
    for (int j = 0; j < N_H1; j++) a1[j] = fire_neuron(a0, N_IN, N_H1, 0, j);
    for (int j = 0; j < N_H2; j++) a2[j] = fire_neuron(a1, N_H1, N_H2, BASE_TWO, j);
    for (int j = 0; j < N_OUT; j++) a3[j] = fire_neuron(a2, N_H2, N_OUT, BASE_THREE, j);
    // running maximum really moves, so an early large output holds its place
    d.action = '0;
    d.score  = a3[0];
    for (int i = 0; i < N_OUT; i++) begin
      if (a3[i] >= d.score) begin
        d.score  = a3[i];
        d.action = 4'(i);
      end
    end
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s, got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    n_mismatches++;
  endtask

  // done_o cannot be held off, so every strobe is consumed at the edge closing it
  always @(posedge clk_i) begin : decision_check
    decision_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_decisions.size() == 0) begin
        report_mismatch("result with nothing pending", {28'd0, action_o}, '0);
      end else begin
        want = pending_decisions.pop_front();
        n_checked++;
        if (action_o !== want.action)
          report_mismatch("action", {28'd0, action_o}, {28'd0, want.action});
        if (best_score_o !== want.score)
          report_mismatch("best score", best_score_o, want.score);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // present one transfer, hold it until accepted, predict, then pace the sender
  task automatic send_item(input logic f, input logic [5:0] idx, input logic [15:0] val,
                           input logic [9:0] x, input logic [9:0] y, input logic [3:0] p);
    int        wv;
    int        gap;
    decision_t d;
    start_i        <= 1'b1;
    func_i         <= f;
    weight_index_i <= idx;
    weight_value_i <= val;
    pos_x_i        <= x;
    pos_y_i        <= y;
    prev_action_i  <= p;
    // values read just after the edge are those the block saw at it
    do @(posedge clk_i); while (busy_o !== 1'b0);
    if (f == FUNC_LOAD) begin
      if (idx < TOTAL_WTS) begin
        wv = int'($signed(val));
        if (wv > W_MAX) wv = W_MAX;
        if (wv < -W_MAX - 1) wv = -W_MAX - 1;
        weight_copy[idx] = wv;
        n_loads++;
        n_accepted++;
      end else begin
        // out-of-range index: the block ignores the transfer
        n_ignored++;
      end
    end else begin
      d = infer_decision(x, y, p);
      pending_decisions.push_back(d);
      if (d.score == '1) n_saturated++;
      if (d.score == '0) n_zero_scores++;
      n_infers++;
      n_accepted++;
    end
    // bursts of random length; the gaps carry junk on the fields with start low
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 12);
      gap        = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 110) : $urandom_range(1, 6);
      repeat (gap) begin
        start_i        <= 1'b0;
        func_i         <= 1'($urandom);
        weight_index_i <= 6'($urandom);
        weight_value_i <= 16'($urandom);
        pos_x_i        <= 10'($urandom);
        pos_y_i        <= 10'($urandom);
        prev_action_i  <= 4'($urandom);
        @(posedge clk_i);
      end
    end
  endtask

  task automatic load_weight(input int idx, input logic [15:0] val);
    send_item(FUNC_LOAD, 6'(idx), val, 10'($urandom), 10'($urandom), 4'($urandom));
  endtask

  task automatic infer(input logic [9:0] x, input logic [9:0] y, input logic [3:0] p);
    send_item(FUNC_INFER, 6'($urandom), 16'($urandom), x, y, p);
  endtask

  task automatic load_uniform(input logic [15:0] val);
    for (int i = 0; i < TOTAL_WTS; i++) load_weight(i, val);
  endtask

  // sender holds off until every pending decision has come back
  task automatic wait_for_results();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_decisions.size() != 0);
  endtask

  function automatic logic [15:0] pick_weight(input int profile);
    case (profile)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 32'h7FFF));
      2: begin
        case ($urandom_range(0, 4))
          0: return W_TOP;
          1: return W_BOTTOM;
          2: return 16'h0000;
          3: return 16'h0001;
          default: return 16'hFFFF;
        endcase
      end
      default: begin
        if ($urandom_range(0, 5) == 0) return 16'(-int'($urandom_range(1, 32'h2000)));
        return 16'($urandom_range(0, 32'h3000));
      end
    endcase
  endfunction

  function automatic logic [9:0] pick_pos();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return POS_TOP;
      2: return 10'($urandom_range(0, 15));
      default: return 10'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // all weights zero: every output is zero, so the last index wins the tie
  task automatic test_zero_weights();
    load_uniform('0);
    infer('0, '0, '0);
    infer(POS_TOP, POS_TOP, PREV_TOP);
    wait_for_results();
  endtask

  // largest weights: the top inputs saturate the outputs, zero inputs give zero scores
  task automatic test_saturation();
    load_uniform(W_TOP);
    infer(POS_TOP, POS_TOP, PREV_TOP);
    infer(POS_TOP, '0, '0);
    infer('0, '0, '0);
    wait_for_results();
  endtask

  // most negative weights: relu clamps the first layer to zero
  task automatic test_negative_weights();
    load_uniform(W_BOTTOM);
    infer(POS_TOP, POS_TOP, PREV_TOP);
    wait_for_results();
  endtask

  // first output largest, then a tie between two middle outputs
  task automatic test_argmax_order();
    for (int i = 0; i < BASE_THREE; i++) load_weight(i, W_ONE);
    for (int k = 0; k < N_H2; k++) begin
      for (int j = 0; j < N_OUT; j++) begin
        case (j)
          0:       load_weight(BASE_THREE + k * N_OUT + j, 16'h4000);
          4:       load_weight(BASE_THREE + k * N_OUT + j, 16'h2000);
          8:       load_weight(BASE_THREE + k * N_OUT + j, 16'h0800);
          default: load_weight(BASE_THREE + k * N_OUT + j, W_MINUS);
        endcase
      end
    end
    // an early winner must survive smaller later outputs
    infer(10'd5, '0, '0);
    for (int k = 0; k < N_H2; k++) begin
      load_weight(BASE_THREE + k * N_OUT + 2, 16'h7000);
      load_weight(BASE_THREE + k * N_OUT + 5, 16'h7000);
    end
    // equal maxima at two outputs: the higher index wins
    infer(10'd5, '0, '0);
    infer('0, '0, PREV_TOP);
    infer('0, POS_TOP, '0);
    wait_for_results();
  endtask

  // loads beyond the store leave the weights untouched
  task automatic test_ignored_loads();
    load_weight(TOTAL_WTS, W_BOTTOM);
    load_weight(63, W_TOP);
    infer(10'd5, '0, '0);
    wait_for_results();
  endtask

  // epochs of a weight profile followed by a run of inferences on random inputs
  task automatic test_random_epochs();
    int goal;
    int profile;
    logic [3:0] prev;
    goal = n_accepted + RANDOM_ITEMS;
    while (n_accepted < goal) begin
      profile = $urandom_range(0, 3);
      if (n_epochs == 0 || $urandom_range(0, 2) == 0) begin
        for (int i = 0; i < TOTAL_WTS; i++) load_weight(i, pick_weight(profile));
      end else begin
        repeat ($urandom_range(1, 8)) load_weight($urandom_range(0, TOTAL_WTS - 1),
                                                  pick_weight(profile));
      end
      // a stray load past the end now and then
      if ($urandom_range(0, 4) == 0) load_weight($urandom_range(TOTAL_WTS, 63), 16'($urandom));
      repeat ($urandom_range(5, 25)) begin
        prev = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 8));
        infer(pick_pos(), pick_pos(), prev);
      end
      if ($urandom_range(0, 5) == 0) wait_for_results();
      n_epochs++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_zero_weights();
    test_saturation();
    test_negative_weights();
    test_argmax_order();
    test_ignored_loads();
    test_random_epochs();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("covered %0d weight loads (%0d past the store), %0d inferences over %0d epochs",
             n_loads, n_ignored, n_infers, n_epochs);
    $display("decisions checked %0d, saturated scores %0d, zero scores %0d, mismatches %0d",
             n_checked, n_saturated, n_zero_scores, n_mismatches);
    if (n_mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // safety net far beyond the slowest correct run
  initial begin
    #6000000;
    $display("timeout with %0d decisions pending", pending_decisions.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/tmai_pkg.sv
sv/tmai_seq.sv
sv/tiny_mlp_argmax_inference.sv
tb/tiny_mlp_argmax_inference_test.sv
